@@ src/pcla_pkg.sv @@
// ----------------------------------------------------------------------------
// pcla_pkg
// Shared widths, register indexes and field codes for the process census
// and load average block.
// ----------------------------------------------------------------------------
package pcla_pkg;

  localparam int FRAC_BITS = 11;
  localparam int CNT_W     = 11;
  localparam int AVG_W     = 22;
  localparam int COEF_W    = 11;
  localparam int SEL_W     = 7;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 3;
  localparam int N_AVG     = 3;

  localparam logic [CNT_W-1:0]     MAX_PROCS = CNT_W'(1024);
  localparam logic [COEF_W:0]      SCALE     = (COEF_W+1)'(1 << FRAC_BITS);
  localparam logic [AVG_W-1:0]     AVG_MAX   = {AVG_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_SLEEP   = 3'd0,
    CFG_WAIT_PRIO   = 3'd1,
    CFG_COEFF_1MIN  = 3'd2,
    CFG_COEFF_5MIN  = 3'd3,
    CFG_COEFF_15MIN = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    REQ_RECORD = 1'b0,
    REQ_END    = 1'b1
  } req_t;

  typedef enum logic [2:0] {
    PST_NONE     = 3'd0,
    PST_SLEEPING = 3'd1,
    PST_STOPPED  = 3'd2,
    PST_RUNNING  = 3'd3,
    PST_CREATING = 3'd4
  } proc_state_t;

endpackage

@@ src/process_census_load_average.sv @@
// ----------------------------------------------------------------------------
// process_census_load_average
// Tallies process records by state and folds the runnable tally into
// 1, 5 and 15 minute exponential load averages on each end-of-sample word.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_ready  | one process record or end marker
//  out_    | output    | out_valid/out_ready| six tallies and three averages
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data
//
// A word passes an input register and, for an end marker, an output register:
// its result follows the end marker into the output register, and one word is
// taken per cycle unless the input stalls. The rate is set by the single decode
// and multiply stage between the two registers; the input stalls only while an
// end marker waits behind a result that has not been taken.
// Synchronous active-low reset clears the tallies, averages and valid flags,
// and restores the default configuration.
// ----------------------------------------------------------------------------
module process_census_load_average (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_req_type,
  input  logic                            in_is_system,
  input  logic [2:0]                      in_proc_state,
  input  logic                            in_in_page_wait,
  input  logic                            in_is_loaded,
  input  logic [pcla_pkg::SEL_W-1:0]      in_priority_req,
  input  logic [pcla_pkg::SEL_W-1:0]      in_sleep_time,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pcla_pkg::CNT_W-1:0]      out_run_count,
  output logic [pcla_pkg::CNT_W-1:0]      out_runq_count,
  output logic [pcla_pkg::CNT_W-1:0]      out_disk_wait_count,
  output logic [pcla_pkg::CNT_W-1:0]      out_page_wait_count,
  output logic [pcla_pkg::CNT_W-1:0]      out_sleep_count,
  output logic [pcla_pkg::CNT_W-1:0]      out_swapped_count,
  output logic [pcla_pkg::AVG_W-1:0]      out_load_1min,
  output logic [pcla_pkg::AVG_W-1:0]      out_load_5min,
  output logic [pcla_pkg::AVG_W-1:0]      out_load_15min,
  input  logic                            cfg_we,
  input  logic [pcla_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcla_pkg::CFG_W-1:0]      cfg_data
);

  localparam int CNT_W  = pcla_pkg::CNT_W;
  localparam int AVG_W  = pcla_pkg::AVG_W;
  localparam int COEF_W = pcla_pkg::COEF_W;
  localparam int SEL_W  = pcla_pkg::SEL_W;
  localparam int PROD_W = COEF_W + 1 + AVG_W;
  localparam int TERM_W = CNT_W + COEF_W + 1;
  localparam int SUM_W  = AVG_W + 2;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] t, input logic en);
    logic [CNT_W-1:0] r;
    r = t;
    if (en && (t < pcla_pkg::MAX_PROCS)) begin
      r = t + CNT_W'(1);
    end
    return r;
  endfunction

  // Configuration registers.
  logic [SEL_W-1:0]  max_sleep_r;
  logic [SEL_W-1:0]  wait_prio_r;
  logic [COEF_W-1:0] coeff_r [pcla_pkg::N_AVG];

  // Input register.
  logic              s1_valid_r;
  logic              s1_req_r;
  logic              s1_sys_r;
  logic [2:0]        s1_state_r;
  logic              s1_page_r;
  logic              s1_loaded_r;
  logic [SEL_W-1:0]  s1_prio_r;
  logic [SEL_W-1:0]  s1_sleep_r;

  // Tallies and averages.
  logic [CNT_W-1:0]  run_r, runq_r, disk_r, page_r, sleep_r, swap_r;
  logic [CNT_W-1:0]  run_nxt, runq_nxt, disk_nxt, page_nxt, sleep_nxt, swap_nxt;
  logic [AVG_W-1:0]  load_r   [pcla_pkg::N_AVG];
  logic [AVG_W-1:0]  load_nxt [pcla_pkg::N_AVG];

  // Output register.
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [CNT_W-1:0]  o_run_r, o_runq_r, o_disk_r, o_page_r, o_sleep_r, o_swap_r;

  logic in_go, is_rec, is_end, end_go;
  logic sleep_like, run_like, pri_low, active, st_sleep;
  logic inc_run, inc_runq, inc_disk, inc_page, inc_sleep, inc_swap;

  assign in_ready = !is_end || end_go;
  assign in_go    = in_valid && in_ready;
  assign is_rec   = s1_valid_r && (s1_req_r == pcla_pkg::REQ_RECORD) && !s1_sys_r;
  assign is_end   = s1_valid_r && (s1_req_r == pcla_pkg::REQ_END);
  assign end_go   = is_end && (!out_valid_r || out_ready);

  always_comb begin
    st_sleep   = (s1_state_r == pcla_pkg::PST_SLEEPING);
    sleep_like = s1_state_r inside {pcla_pkg::PST_SLEEPING, pcla_pkg::PST_STOPPED};
    run_like   = s1_state_r inside {pcla_pkg::PST_RUNNING, pcla_pkg::PST_CREATING};
    pri_low    = (s1_prio_r <= wait_prio_r);
    active     = (s1_sleep_r < max_sleep_r);

    inc_run   = is_rec && ((st_sleep && pri_low && (s1_sleep_r == '0)) || run_like);
    inc_runq  = is_rec && run_like && s1_loaded_r;
    inc_page  = is_rec && sleep_like && s1_page_r;
    inc_disk  = is_rec && sleep_like && !s1_page_r && s1_loaded_r && pri_low;
    inc_sleep = is_rec && sleep_like && !s1_page_r && s1_loaded_r && !pri_low && active;
    inc_swap  = is_rec && ((sleep_like && !s1_page_r && !s1_loaded_r && active) ||
                           (run_like && !s1_loaded_r));

    if (end_go) begin
      run_nxt   = '0;
      runq_nxt  = '0;
      disk_nxt  = '0;
      page_nxt  = '0;
      sleep_nxt = '0;
      swap_nxt  = '0;
    end else begin
      run_nxt   = sat_inc(run_r,   inc_run);
      runq_nxt  = sat_inc(runq_r,  inc_runq);
      disk_nxt  = sat_inc(disk_r,  inc_disk);
      page_nxt  = sat_inc(page_r,  inc_page);
      sleep_nxt = sat_inc(sleep_r, inc_sleep);
      swap_nxt  = sat_inc(swap_r,  inc_swap);
    end
  end

  // The new average is (c * avg >> F) + n * (2^F - c), saturated.
  always_comb begin
    logic [COEF_W:0]  cc;
    logic [COEF_W:0]  wgt;
    logic [PROD_W-1:0] prod;
    logic [TERM_W-1:0] term;
    logic [SUM_W-1:0]  sum;
    for (int i = 0; i < pcla_pkg::N_AVG; i++) begin
      cc   = {1'b0, coeff_r[i]};
      if (cc > pcla_pkg::SCALE) begin
        cc = pcla_pkg::SCALE;
      end
      wgt  = pcla_pkg::SCALE - cc;
      prod = PROD_W'(cc) * PROD_W'(load_r[i]);
      term = TERM_W'(run_r) * TERM_W'(wgt);
      sum  = SUM_W'(prod >> pcla_pkg::FRAC_BITS) + SUM_W'(term);
      if (sum > SUM_W'(pcla_pkg::AVG_MAX)) begin
        load_nxt[i] = pcla_pkg::AVG_MAX;
      end else begin
        load_nxt[i] = sum[AVG_W-1:0];
      end
    end
  end

  assign out_valid_nxt = end_go || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_sleep_r <= SEL_W'(20);
      wait_prio_r <= SEL_W'(25);
      coeff_r[0]  <= COEF_W'(1884);
      coeff_r[1]  <= COEF_W'(2014);
      coeff_r[2]  <= COEF_W'(2036);
    end else if (cfg_we) begin
      case (cfg_index)
        pcla_pkg::CFG_MAX_SLEEP:   max_sleep_r <= cfg_data[SEL_W-1:0];
        pcla_pkg::CFG_WAIT_PRIO:   wait_prio_r <= cfg_data[SEL_W-1:0];
        pcla_pkg::CFG_COEFF_1MIN:  coeff_r[0]  <= cfg_data[COEF_W-1:0];
        pcla_pkg::CFG_COEFF_5MIN:  coeff_r[1]  <= cfg_data[COEF_W-1:0];
        pcla_pkg::CFG_COEFF_15MIN: coeff_r[2]  <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
      runq_r      <= '0;
      disk_r      <= '0;
      page_r      <= '0;
      sleep_r     <= '0;
      swap_r      <= '0;
      for (int i = 0; i < pcla_pkg::N_AVG; i++) begin
        load_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= in_go || (is_end && !end_go);
      out_valid_r <= out_valid_nxt;
      run_r       <= run_nxt;
      runq_r      <= runq_nxt;
      disk_r      <= disk_nxt;
      page_r      <= page_nxt;
      sleep_r     <= sleep_nxt;
      swap_r      <= swap_nxt;
      if (end_go) begin
        for (int i = 0; i < pcla_pkg::N_AVG; i++) begin
          load_r[i] <= load_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      s1_req_r    <= in_req_type;
      s1_sys_r    <= in_is_system;
      s1_state_r  <= in_proc_state;
      s1_page_r   <= in_in_page_wait;
      s1_loaded_r <= in_is_loaded;
      s1_prio_r   <= in_priority_req;
      s1_sleep_r  <= in_sleep_time;
    end
    if (end_go) begin
      o_run_r   <= run_r;
      o_runq_r  <= runq_r;
      o_disk_r  <= disk_r;
      o_page_r  <= page_r;
      o_sleep_r <= sleep_r;
      o_swap_r  <= swap_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_run_count       = o_run_r;
  assign out_runq_count      = o_runq_r;
  assign out_disk_wait_count = o_disk_r;
  assign out_page_wait_count = o_page_r;
  assign out_sleep_count     = o_sleep_r;
  assign out_swapped_count   = o_swap_r;
  assign out_load_1min       = load_r[0];
  assign out_load_5min       = load_r[1];
  assign out_load_15min      = load_r[2];

  a_tally_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (run_r <= pcla_pkg::MAX_PROCS) && (swap_r <= pcla_pkg::MAX_PROCS))
    else $error("tally above the process limit");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    end_go |=> (run_r == '0) && (runq_r == '0) && (disk_r == '0) &&
               (page_r == '0) && (sleep_r == '0) && (swap_r == '0))
    else $error("tallies not cleared after an end word");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (is_end && out_valid_r))
    else $error("input stalled without a pending end word");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(end_go))
    else $error("result raised without an end word");

  a_avg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !end_go |=> $stable(load_r[0]) && $stable(load_r[2]))
    else $error("average changed outside an end word");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the process census and load average block. A
// queue of process records and end-of-sample words feeds a valid/ready
// driver, and a running model of the tallies and the three averages
// predicts each result word. The monitor checks every field against the
// oldest prediction. Phases cover directed corner records, configuration
// extremes, a longer tally run and random traffic with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int SEL_W     = pcla_pkg::SEL_W;
  localparam int CNT_W     = pcla_pkg::CNT_W;
  localparam int AVG_W     = pcla_pkg::AVG_W;
  localparam int COEF_W    = pcla_pkg::COEF_W;
  localparam int N_AVG     = pcla_pkg::N_AVG;
  localparam int CFG_W     = pcla_pkg::CFG_W;
  localparam int CFG_IDX_W = pcla_pkg::CFG_IDX_W;
  localparam int FRAC_BITS = pcla_pkg::FRAC_BITS;

  localparam int LIMIT        = 1000000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP      = 16;
  localparam int SAT_WORDS    = 120;
  localparam int RAND_WORDS   = 30;

  localparam int T_RUN   = 0;
  localparam int T_RUNQ  = 1;
  localparam int T_DISK  = 2;
  localparam int T_PAGE  = 3;
  localparam int T_SLEEP = 4;
  localparam int T_SWAP  = 5;

  typedef struct packed {
    pcla_pkg::req_t   req;
    logic             sys;
    logic [2:0]       pst;
    logic             page;
    logic             loaded;
    logic [SEL_W-1:0] prio;
    logic [SEL_W-1:0] slp;
  } census_word_t;

  typedef struct packed {
    logic [5:0][CNT_W-1:0]       cnt;
    logic [N_AVG-1:0][AVG_W-1:0] avg;
  } census_sample_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic                 in_is_system = 1'b0;
  logic [2:0]           in_proc_state = '0;
  logic                 in_in_page_wait = 1'b0;
  logic                 in_is_loaded = 1'b0;
  logic [SEL_W-1:0]     in_priority_req = '0;
  logic [SEL_W-1:0]     in_sleep_time = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CNT_W-1:0]     out_run_count;
  logic [CNT_W-1:0]     out_runq_count;
  logic [CNT_W-1:0]     out_disk_wait_count;
  logic [CNT_W-1:0]     out_page_wait_count;
  logic [CNT_W-1:0]     out_sleep_count;
  logic [CNT_W-1:0]     out_swapped_count;
  logic [AVG_W-1:0]     out_load_1min;
  logic [AVG_W-1:0]     out_load_5min;
  logic [AVG_W-1:0]     out_load_15min;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  census_word_t   word_q [$];
  census_sample_t sample_q [$];
  census_word_t   cur_word;
  census_sample_t want_sample;
  census_sample_t got_sample;

  logic [SEL_W-1:0]             max_sleep = SEL_W'(20);
  logic [SEL_W-1:0]             wait_prio = SEL_W'(25);
  logic [N_AVG-1:0][COEF_W-1:0] coeff = {COEF_W'(2036), COEF_W'(2014), COEF_W'(1884)};
  logic [5:0][CNT_W-1:0]        tally = '0;
  logic [N_AVG-1:0][AVG_W-1:0]  load_avg = '0;

  string cnt_name [6] = '{"run_count", "runq_count", "disk_wait_count",
                          "page_wait_count", "sleep_count", "swapped_count"};
  string avg_name [3] = '{"load_1min", "load_5min", "load_15min"};

  int  errors = 0;
  int  cycle_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  in_idle = 1'b1;
  bit  out_idle = 1'b1;

  process_census_load_average u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_req_type         (in_req_type),
    .in_is_system        (in_is_system),
    .in_proc_state       (in_proc_state),
    .in_in_page_wait     (in_in_page_wait),
    .in_is_loaded        (in_is_loaded),
    .in_priority_req     (in_priority_req),
    .in_sleep_time       (in_sleep_time),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_run_count       (out_run_count),
    .out_runq_count      (out_runq_count),
    .out_disk_wait_count (out_disk_wait_count),
    .out_page_wait_count (out_page_wait_count),
    .out_sleep_count     (out_sleep_count),
    .out_swapped_count   (out_swapped_count),
    .out_load_1min       (out_load_1min),
    .out_load_5min       (out_load_5min),
    .out_load_15min      (out_load_15min),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    return (x < pcla_pkg::MAX_PROCS) ? x + CNT_W'(1) : x;
  endfunction

  function automatic logic [AVG_W-1:0] decay(input logic [AVG_W-1:0] avg,
                                             input logic [COEF_W-1:0] c,
                                             input logic [CNT_W-1:0] n);
    longint unsigned scale;
    longint unsigned cc;
    longint unsigned v;
    scale = longint'(1) << FRAC_BITS;
    cc = (longint'(c) > scale) ? scale : longint'(c);
    v = (cc * longint'(avg) + longint'(n) * scale * (scale - cc)) >> FRAC_BITS;
    return (v > longint'(pcla_pkg::AVG_MAX)) ? pcla_pkg::AVG_MAX : v[AVG_W-1:0];
  endfunction

  function automatic census_word_t mk(input pcla_pkg::req_t req, input logic sys,
                                      input logic [2:0] pst, input logic page,
                                      input logic loaded, input logic [SEL_W-1:0] prio,
                                      input logic [SEL_W-1:0] slp);
    census_word_t w;
    w.req = req;
    w.sys = sys;
    w.pst = pst;
    w.page = page;
    w.loaded = loaded;
    w.prio = prio;
    w.slp = slp;
    return w;
  endfunction

  function automatic census_word_t random_word();
    census_word_t w;
    int r;
    w.req = ($urandom_range(0, 9) == 0) ? pcla_pkg::REQ_END : pcla_pkg::REQ_RECORD;
    w.sys = 1'($urandom_range(0, 7) == 0);
    w.pst = ($urandom_range(0, 9) < 8) ?
            3'($urandom_range(pcla_pkg::PST_SLEEPING, pcla_pkg::PST_CREATING)) :
            3'($urandom_range(0, 7));
    w.page = 1'($urandom_range(0, 3) == 0);
    w.loaded = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 3);
    w.prio = (r == 0) ? wait_prio : (r == 1) ? wait_prio + SEL_W'(1)
                                             : SEL_W'($urandom_range(0, 127));
    r = $urandom_range(0, 4);
    w.slp = (r == 0) ? '0 : (r == 1) ? max_sleep : (r == 2) ? max_sleep - SEL_W'(1)
                                                            : SEL_W'($urandom_range(0, 127));
    if ($urandom_range(0, 4) == 0) begin
      w.sys = 1'($urandom_range(0, 1));
      w.pst = 3'($urandom_range(0, 7));
      w.page = 1'($urandom_range(0, 1));
      w.prio = SEL_W'($urandom_range(0, 127));
      w.slp = SEL_W'($urandom_range(0, 127));
    end
    return w;
  endfunction

  task automatic census_update(input census_word_t w);
    census_sample_t s;
    logic act;
    logic urgent;
    act = w.slp < max_sleep;
    urgent = w.prio <= wait_prio;
    if (w.req == pcla_pkg::REQ_END) begin
      for (int i = 0; i < N_AVG; i++) begin
        load_avg[i] = decay(load_avg[i], coeff[i], tally[T_RUN]);
      end
      s.cnt = tally;
      s.avg = load_avg;
      sample_q.push_back(s);
      tally = '0;
    end else if (!w.sys) begin
      if (w.pst == pcla_pkg::PST_SLEEPING || w.pst == pcla_pkg::PST_STOPPED) begin
        if (w.pst == pcla_pkg::PST_SLEEPING && urgent && w.slp == '0) begin
          tally[T_RUN] = sat_inc(tally[T_RUN]);
        end
        if (w.page) begin
          tally[T_PAGE] = sat_inc(tally[T_PAGE]);
        end else if (w.loaded) begin
          if (urgent) begin
            tally[T_DISK] = sat_inc(tally[T_DISK]);
          end else if (act) begin
            tally[T_SLEEP] = sat_inc(tally[T_SLEEP]);
          end
        end else if (act) begin
          tally[T_SWAP] = sat_inc(tally[T_SWAP]);
        end
      end else if (w.pst == pcla_pkg::PST_RUNNING || w.pst == pcla_pkg::PST_CREATING) begin
        tally[T_RUN] = sat_inc(tally[T_RUN]);
        if (w.loaded) begin
          tally[T_RUNQ] = sat_inc(tally[T_RUNQ]);
        end else begin
          tally[T_SWAP] = sat_inc(tally[T_SWAP]);
        end
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      pcla_pkg::CFG_MAX_SLEEP:   max_sleep = val[SEL_W-1:0];
      pcla_pkg::CFG_WAIT_PRIO:   wait_prio = val[SEL_W-1:0];
      pcla_pkg::CFG_COEFF_1MIN:  coeff[0] = val;
      pcla_pkg::CFG_COEFF_5MIN:  coeff[1] = val;
      pcla_pkg::CFG_COEFF_15MIN: coeff[2] = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    while (word_q.size() != 0 || in_valid || sample_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config();
    int r;
    for (int i = pcla_pkg::CFG_MAX_SLEEP; i <= pcla_pkg::CFG_COEFF_15MIN; i++) begin
      r = $urandom_range(0, 3);
      write_reg(CFG_IDX_W'(i), (r == 0) ? '0 : (r == 1) ? '1 : CFG_W'($urandom_range(0, 2047)));
    end
  endtask

  task automatic run_random(input int n);
    in_idle = ($urandom_range(0, 3) != 0);
    out_idle = ($urandom_range(0, 3) != 0);
    for (int i = 0; i < n; i++) word_q.push_back(random_word());
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b0, pcla_pkg::PST_NONE, 1'b0, 1'b0, '0, '0));
    wait_idle();
  endtask

  task automatic run_saturation();
    census_word_t w;
    for (int i = 0; i < SAT_WORDS; i++) begin
      w = mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_NONE, 1'($urandom_range(0, 1)), 1'b1,
             SEL_W'($urandom_range(0, 127)), SEL_W'($urandom_range(0, 127)));
      case ($urandom_range(0, 4))
        0: w.pst = pcla_pkg::PST_RUNNING;
        1: begin
          w.pst = pcla_pkg::PST_CREATING;
          w.loaded = 1'b0;
        end
        2: begin
          w.pst = pcla_pkg::PST_SLEEPING;
          w.page = 1'b1;
          w.loaded = 1'($urandom_range(0, 1));
          w.prio = SEL_W'($urandom_range(0, wait_prio));
          w.slp = '0;
        end
        3: begin
          w.pst = pcla_pkg::PST_STOPPED;
          w.page = 1'b0;
          w.prio = SEL_W'($urandom_range(0, wait_prio));
        end
        default: begin
          w.pst = pcla_pkg::PST_STOPPED;
          w.page = 1'b0;
          w.prio = SEL_W'($urandom_range(wait_prio + 1, 127));
          w.slp = SEL_W'($urandom_range(0, max_sleep - 1));
        end
      endcase
      word_q.push_back(w);
    end
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b0, pcla_pkg::PST_NONE, 1'b0, 1'b0, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b0, pcla_pkg::PST_NONE, 1'b0, 1'b0, '0, '0));
    wait_idle();
  endtask

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        census_update(cur_word);
        gap_left = in_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (word_q.size() != 0) begin
          cur_word = word_q.pop_front();
          in_req_type <= cur_word.req;
          in_is_system <= cur_word.sys;
          in_proc_state <= cur_word.pst;
          in_in_page_wait <= cur_word.page;
          in_is_loaded <= cur_word.loaded;
          in_priority_req <= cur_word.prio;
          in_sleep_time <= cur_word.slp;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (sample_q.size() == 0) begin
          $error("result word with no sample pending");
          errors++;
        end else begin
          want_sample = sample_q.pop_front();
          got_sample.cnt = {out_swapped_count, out_sleep_count, out_page_wait_count,
                            out_disk_wait_count, out_runq_count, out_run_count};
          got_sample.avg = {out_load_15min, out_load_5min, out_load_1min};
          for (int i = 0; i < 6; i++) begin
            if (got_sample.cnt[i] !== want_sample.cnt[i]) begin
              $error("%s: expected %0d, got %0d", cnt_name[i], want_sample.cnt[i],
                     got_sample.cnt[i]);
              errors++;
            end
          end
          for (int i = 0; i < N_AVG; i++) begin
            if (got_sample.avg[i] !== want_sample.avg[i]) begin
              $error("%s: expected %0d, got %0d", avg_name[i], want_sample.avg[i],
                     got_sample.avg[i]);
              errors++;
            end
          end
        end
        stall_left = out_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Defaults: max_sleep 20, wait_priority 25.
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b1, 3'b111, 1'b1, 1'b1, '1, '1));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_RUNNING,
                        1'b0, 1'b1, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_CREATING,
                        1'b1, 1'b0, '1, '1));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_SLEEPING,
                        1'b0, 1'b1, 7'd25, 7'd0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_SLEEPING,
                        1'b0, 1'b1, 7'd26, 7'd0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_SLEEPING,
                        1'b0, 1'b1, 7'd26, 7'd20));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_SLEEPING,
                        1'b1, 1'b0, 7'd10, 7'd5));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_SLEEPING,
                        1'b0, 1'b0, 7'd26, 7'd19));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_STOPPED,
                        1'b0, 1'b1, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_STOPPED,
                        1'b0, 1'b0, '1, 7'd19));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_STOPPED,
                        1'b0, 1'b0, '1, '1));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_NONE,
                        1'b0, 1'b1, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_CREATING + 3'd1,
                        1'b0, 1'b1, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_CREATING + 3'd2,
                        1'b1, 1'b0, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_CREATING + 3'd3,
                        1'b0, 1'b1, '1, '1));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b1, pcla_pkg::PST_RUNNING,
                        1'b0, 1'b1, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b1, pcla_pkg::PST_RUNNING,
                        1'b0, 1'b0, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b0, pcla_pkg::PST_NONE,
                        1'b0, 1'b0, '0, '0));
    word_q.push_back(mk(pcla_pkg::REQ_RECORD, 1'b0, pcla_pkg::PST_RUNNING,
                        1'b1, 1'b0, '1, '1));
    word_q.push_back(mk(pcla_pkg::REQ_END, 1'b0, pcla_pkg::PST_NONE,
                        1'b0, 1'b0, '0, '0));
    wait_idle();

    write_reg(pcla_pkg::CFG_MAX_SLEEP, '1);
    write_reg(pcla_pkg::CFG_WAIT_PRIO, '0);
    write_reg(pcla_pkg::CFG_COEFF_1MIN, '1);
    write_reg(pcla_pkg::CFG_COEFF_5MIN, '0);
    write_reg(pcla_pkg::CFG_COEFF_15MIN, CFG_W'(1024));
    for (int k = 1; k <= 3; k++) begin
      write_reg(pcla_pkg::CFG_COEFF_15MIN + CFG_IDX_W'(k), CFG_W'($urandom_range(0, 2047)));
    end
    run_random(RAND_WORDS);

    write_reg(pcla_pkg::CFG_MAX_SLEEP, CFG_W'(100));
    write_reg(pcla_pkg::CFG_WAIT_PRIO, CFG_W'(60));
    write_reg(pcla_pkg::CFG_COEFF_1MIN, '0);
    write_reg(pcla_pkg::CFG_COEFF_5MIN, '1);
    write_reg(pcla_pkg::CFG_COEFF_15MIN, CFG_W'($urandom_range(0, 2047)));
    in_idle = 1'b1;
    out_idle = 1'b1;
    run_saturation();

    write_reg(pcla_pkg::CFG_MAX_SLEEP, '0);
    write_reg(pcla_pkg::CFG_WAIT_PRIO, '1);
    run_random(RAND_WORDS);

    for (int p = 0; p < 6; p++) begin
      random_config();
      run_random(RAND_WORDS);
    end

    wait_idle();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
